// File: rtl/core/s2rgb_pkg.sv
package s2rgb_pkg;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int HEIGHT_LIMIT    = 4096;

    localparam int SAMPLE_W    = 16;
    localparam int PREC_W      = 5;
    localparam int ROW_W       = 12;
    localparam int HEIGHT_W    = 13;
    localparam int SIZE_W      = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PAIR_W      = 2 * SAMPLE_W;

    localparam int FRAC_BITS = 20;
    localparam int COEF_W    = 23;
    localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
    localparam int ACC_W     = PROD_W + 2;

    localparam logic signed [COEF_W-1:0] COEF_RY = 23'sd1048576;
    localparam logic signed [COEF_W-1:0] COEF_RB = -23'sd39;
    localparam logic signed [COEF_W-1:0] COEF_RR = 23'sd1470093;
    localparam logic signed [COEF_W-1:0] COEF_GY = 23'sd1048891;
    localparam logic signed [COEF_W-1:0] COEF_GB = -23'sd360841;
    localparam logic signed [COEF_W-1:0] COEF_GR = -23'sd748802;
    localparam logic signed [COEF_W-1:0] COEF_BY = 23'sd1048390;
    localparam logic signed [COEF_W-1:0] COEF_BB = 23'sd1858119;
    localparam logic signed [COEF_W-1:0] COEF_BR = -23'sd8;
    localparam logic signed [ACC_W-1:0]  HALF_UNIT = 42'sd524288;

    typedef enum logic [1:0] {
        MODE_444 = 2'd0,
        MODE_422 = 2'd1,
        MODE_420 = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRECISION = 3'd0,
        CFG_MODE      = 3'd1,
        CFG_WIDTH     = 3'd2,
        CFG_HEIGHT    = 3'd3,
        CFG_X_ODD     = 3'd4,
        CFG_Y_ODD     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma_sample;
        logic [SAMPLE_W-1:0] cb_sample;
        logic [SAMPLE_W-1:0] cr_sample;
    } in_pix_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic                chroma_taken;
        logic                image_end;
    } out_pix_t;

    typedef struct packed {
        logic [PREC_W-1:0]   precision;
        mode_t               mode;
        logic [HEIGHT_W-1:0] height;
        logic                x_odd;
        logic                y_odd;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
        logic                taken;
        logic                image_end;
    } pix_t;

    function automatic logic [SAMPLE_W-1:0] sample_mask(input logic [PREC_W-1:0] prec);
        logic [SAMPLE_W:0] full;
        full = ({{SAMPLE_W{1'b0}}, 1'b1} << prec) - {{SAMPLE_W{1'b0}}, 1'b1};
        return full[SAMPLE_W-1:0];
    endfunction

endpackage

// File: rtl/core/sycc_to_rgb_upsampling_converter.sv
// sYCC to RGB converter with 4:4:4, 4:2:2 and 4:2:0 chroma upsampling. Pixels enter in raster
// order, one per clock, each with its luma sample and the chroma pair the source offers next;
// chroma_taken on the result tells the source to advance. Sustained rate is one pixel per cycle
// while m_ready stays high, and each pixel's result reaches the output register by way of four
// register stages in turn (line store read, chroma offset, multiply, sum and clamp).
// The upper row of each 4:2:0 row pair writes its chroma into a single-port line store of
// (MAX_WIDTH+1)/2 pairs that the lower row reads back; the store needs no clearing after reset.
// cfg_ready is always high and registers should only be written between images while the
// pipeline is empty; out-of-range values are clamped on write.
module sycc_to_rgb_upsampling_converter
    import s2rgb_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_pix_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_pix_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    cfg_t          cfg_reg, cfg_next;
    logic [WW-1:0] width_reg, width_next;
    logic [31:0]   size32;
    logic          pix_valid, pix_ready;
    pix_t          pix;

    assign cfg_ready = 1'b1;
    assign size32    = {{(32-SIZE_W){1'b0}}, cfg_data[SIZE_W-1:0]};

    always_comb begin
        cfg_next   = cfg_reg;
        width_next = width_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PRECISION: begin
                    if (cfg_data[PREC_W-1:0] == '0) begin
                        cfg_next.precision = PREC_W'(1);
                    end else if (int'(cfg_data[PREC_W-1:0]) > SAMPLE_BITS) begin
                        cfg_next.precision = PREC_W'(SAMPLE_BITS);
                    end else begin
                        cfg_next.precision = cfg_data[PREC_W-1:0];
                    end
                end
                CFG_MODE: begin
                    if (cfg_data[1:0] == MODE_420) begin
                        cfg_next.mode = MODE_420;
                    end else if (cfg_data[1:0] == MODE_422) begin
                        cfg_next.mode = MODE_422;
                    end else begin
                        cfg_next.mode = MODE_444;
                    end
                end
                CFG_WIDTH: begin
                    if (size32 == '0) begin
                        width_next = WW'(1);
                    end else if (size32 > 32'(MAX_WIDTH)) begin
                        width_next = WW'(MAX_WIDTH);
                    end else begin
                        width_next = size32[WW-1:0];
                    end
                end
                CFG_HEIGHT: begin
                    if (size32 == '0) begin
                        cfg_next.height = HEIGHT_W'(1);
                    end else if (size32 > 32'(HEIGHT_LIMIT)) begin
                        cfg_next.height = HEIGHT_W'(HEIGHT_LIMIT);
                    end else begin
                        cfg_next.height = size32[HEIGHT_W-1:0];
                    end
                end
                CFG_X_ODD: cfg_next.x_odd = cfg_data[0];
                CFG_Y_ODD: cfg_next.y_odd = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.precision <= PREC_W'(8);
            cfg_reg.mode      <= MODE_444;
            cfg_reg.height    <= HEIGHT_W'(1);
            cfg_reg.x_odd     <= 1'b0;
            cfg_reg.y_odd     <= 1'b0;
            width_reg         <= WW'(1);
        end else begin
            cfg_reg   <= cfg_next;
            width_reg <= width_next;
        end
    end

    s2rgb_chroma_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .WW        (WW)
    ) u_chroma_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .image_width (width_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix         (pix)
    );

    s2rgb_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .precision (cfg_reg.precision),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: rtl/core/s2rgb_chroma_ctrl.sv
module s2rgb_chroma_ctrl
    import s2rgb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfg_t          cfg,
    input  logic [WW-1:0] image_width,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_pix_t       s_data,
    output logic          pix_valid,
    input  logic          pix_ready,
    output pix_t          pix
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int IW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [CW-1:0]     col_reg, col_next, col_cur, k;
    logic [CW:0]       col_inc, k_half;
    logic [ROW_W-1:0]  row_reg, row_next, row_cur;
    logic [ROW_W:0]    row_inc;
    logic [PAIR_W-1:0] held_reg, held_next;
    logic              col_last, row_last;
    logic              accept, sub, first_row_zero, lower, zero;
    logic              use_store, taken, held_use, mem_we, mem_re;
    logic [IW-1:0]     idx;
    logic [SAMPLE_W-1:0] mask;
    logic [PAIR_W-1:0] pair_in, pair_sel;

    logic                va_reg, va_next;
    logic [SAMPLE_W-1:0] luma_a_reg;
    logic [PAIR_W-1:0]   pair_a_reg;
    logic                use_store_a_reg, taken_a_reg, end_a_reg;
    logic [PAIR_W-1:0]   store_rd_reg;

    logic [PAIR_W-1:0] line_mem [LINE_DEPTH];

    assign accept = s_valid && s_ready;
    assign s_ready = !va_reg || pix_ready;

    always_comb begin
        col_cur  = (col_reg >= image_width) ? '0 : col_reg;
        row_cur  = (row_reg >= cfg.height) ? '0 : row_reg;
        col_inc  = {1'b0, col_cur} + {{CW{1'b0}}, 1'b1};
        row_inc  = {1'b0, row_cur} + {{ROW_W{1'b0}}, 1'b1};
        col_last = col_inc >= image_width;
        row_last = row_inc >= cfg.height;

        mask    = sample_mask(cfg.precision);
        pair_in = {s_data.cr_sample & mask, s_data.cb_sample & mask};

        sub            = (cfg.mode == MODE_422) || (cfg.mode == MODE_420);
        first_row_zero = (cfg.mode == MODE_420) && cfg.y_odd && (row_cur == '0);
        lower          = (cfg.mode == MODE_420) && !first_row_zero
                         && (row_cur[0] ^ cfg.y_odd);
        zero           = sub && (first_row_zero || (cfg.x_odd && (col_cur == '0)));
        k              = col_cur - CW'(cfg.x_odd);
        k_half         = {1'b0, k} >> 1;
        idx            = k_half[IW-1:0];

        use_store = sub && !zero && lower;
        held_use  = sub && !zero && !lower && k[0];
        taken     = !sub || (!zero && !lower && !k[0]);
        pair_sel  = zero ? '0 : (held_use ? held_reg : pair_in);

        mem_we = accept && taken && (cfg.mode == MODE_420);
        mem_re = accept && use_store;
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[CW-1:0];
                row_next = row_cur;
            end
            if (sub && taken) begin
                held_next = pair_in;
            end
        end
        va_next = s_ready ? s_valid : va_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
            va_reg   <= 1'b0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
            va_reg   <= va_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            luma_a_reg      <= s_data.luma_sample & mask;
            pair_a_reg      <= pair_sel;
            use_store_a_reg <= use_store;
            taken_a_reg     <= taken;
            end_a_reg       <= col_last && row_last;
        end
    end

    // chroma line store, one pair per chroma column
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[idx] <= pair_in;
        end
        if (mem_re) begin
            store_rd_reg <= line_mem[idx];
        end
    end

    always_comb begin
        pix_valid     = va_reg;
        pix.luma      = luma_a_reg;
        {pix.cr, pix.cb} = use_store_a_reg ? store_rd_reg : pair_a_reg;
        pix.taken     = taken_a_reg;
        pix.image_end = end_a_reg;
    end

    a_store_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("line store read and write in the same cycle");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        va_reg && !pix_ready |=> va_reg && $stable(pair_a_reg) && $stable(use_store_a_reg))
        else $error("stalled pixel lost its chroma");

    a_src_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        va_reg |-> !(use_store_a_reg && taken_a_reg))
        else $error("line store pixel marked as taking input chroma");

endmodule

// File: rtl/core/s2rgb_matrix.sv
module s2rgb_matrix
    import s2rgb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [PREC_W-1:0] precision,
    input  logic              pix_valid,
    output logic              pix_ready,
    input  pix_t              pix,
    output logic              m_valid,
    input  logic              m_ready,
    output out_pix_t          m_data
);

    logic en_b, en_c, en_d;
    logic vb_reg, vc_reg, vd_reg;

    logic [SAMPLE_W-1:0]        off;
    logic [SAMPLE_W-1:0]        top;
    logic signed [SAMPLE_W:0]   y_next, cb_next, cr_next;
    logic signed [SAMPLE_W:0]   y_b_reg, cb_b_reg, cr_b_reg;
    logic                       taken_b_reg, end_b_reg;

    logic signed [PROD_W-1:0]   prod_next [9];
    logic signed [PROD_W-1:0]   prod_reg  [9];
    logic                       taken_c_reg, end_c_reg;

    logic signed [ACC_W-1:0]    acc_r, acc_g, acc_b;
    out_pix_t                   out_next, out_reg;

    function automatic logic [SAMPLE_W-1:0] clamp_sample(
        input logic signed [ACC_W-1:0] acc,
        input logic [SAMPLE_W-1:0]     limit
    );
        logic [ACC_W-1:0] q;
        q = $unsigned(acc) >> FRAC_BITS;
        if (acc < 0) begin
            return '0;
        end else if (q > {{(ACC_W-SAMPLE_W){1'b0}}, limit}) begin
            return limit;
        end else begin
            return q[SAMPLE_W-1:0];
        end
    endfunction

    assign en_d      = !vd_reg || m_ready;
    assign en_c      = !vc_reg || en_d;
    assign en_b      = !vb_reg || en_c;
    assign pix_ready = en_b;
    assign m_valid   = vd_reg;
    assign m_data    = out_reg;

    always_comb begin
        off     = {{(SAMPLE_W-1){1'b0}}, 1'b1} << (precision - 1'b1);
        top     = sample_mask(precision);
        y_next  = $signed({1'b0, pix.luma});
        cb_next = $signed({1'b0, pix.cb}) - $signed({1'b0, off});
        cr_next = $signed({1'b0, pix.cr}) - $signed({1'b0, off});
    end

    always_comb begin
        prod_next[0] = COEF_RY * y_b_reg;
        prod_next[1] = COEF_RB * cb_b_reg;
        prod_next[2] = COEF_RR * cr_b_reg;
        prod_next[3] = COEF_GY * y_b_reg;
        prod_next[4] = COEF_GB * cb_b_reg;
        prod_next[5] = COEF_GR * cr_b_reg;
        prod_next[6] = COEF_BY * y_b_reg;
        prod_next[7] = COEF_BB * cb_b_reg;
        prod_next[8] = COEF_BR * cr_b_reg;
    end

    always_comb begin
        acc_r = prod_reg[0] + prod_reg[1] + prod_reg[2] + HALF_UNIT;
        acc_g = prod_reg[3] + prod_reg[4] + prod_reg[5] + HALF_UNIT;
        acc_b = prod_reg[6] + prod_reg[7] + prod_reg[8] + HALF_UNIT;
        out_next.red          = clamp_sample(acc_r, top);
        out_next.green        = clamp_sample(acc_g, top);
        out_next.blue         = clamp_sample(acc_b, top);
        out_next.chroma_taken = taken_c_reg;
        out_next.image_end    = end_c_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (en_b) begin
                vb_reg <= pix_valid;
            end
            if (en_c) begin
                vc_reg <= vb_reg;
            end
            if (en_d) begin
                vd_reg <= vc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b && pix_valid) begin
            y_b_reg     <= y_next;
            cb_b_reg    <= cb_next;
            cr_b_reg    <= cr_next;
            taken_b_reg <= pix.taken;
            end_b_reg   <= pix.image_end;
        end
        if (en_c && vb_reg) begin
            prod_reg    <= prod_next;
            taken_c_reg <= taken_b_reg;
            end_c_reg   <= end_b_reg;
        end
        if (en_d && vc_reg) begin
            out_reg <= out_next;
        end
    end

endmodule
